>>> rtl/kdpp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kdpp_pkg
// shared types and constants of the keyframe duty pattern player
// ----------------------------------------------------------------------------
package kdpp_pkg;

  // input operation codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;
  localparam logic [1:0] FUNC_TICK  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_LINE_COUNT = 2'd0;
  localparam logic [1:0] REG_LENGTH     = 2'd1;
  localparam logic [1:0] REG_LOOP       = 2'd2;

  localparam logic [6:0]  DUTY_MAX      = 7'd100;
  localparam logic [7:0]  PROGRESS_FULL = 8'd255;
  localparam logic [11:0] RAMP_UNIT_US  = 12'd4000;

  // keyframe entry as stored: linear, duty, ramp, offset from the msb down
  typedef struct packed {
    logic        linear;
    logic [6:0]  duty;
    logic [7:0]  ramp;
    logic [31:0] offset;
  } key_t;

  localparam int KEY_W = $bits(key_t);

endpackage
`default_nettype wire

>>> rtl/kdpp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kdpp_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module kdpp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/keyframe_duty_pattern_player_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_duty_pattern_player_top
// plays a keyframe table into an actuator duty percent
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command beat, its operation (write keyframe, start,
//   stop, tick) in tuser; m_axis returns exactly one result beat per command.
//   cfg writes the line count, pattern length and loop enable; the user must
//   write them only while the block is idle; the block does not enforce it.
//   Write, start, stop, a tick that drives nothing and a tick that ends a
//   one-shot give a result in the cycle after acceptance. A looped tick
//   first runs a restoring divide of the 64-bit elapsed time by the pattern
//   length, one quotient bit per cycle, keeping the remainder. A driving
//   tick then walks the keyframe table down from the last key in use, one
//   key per S_SRCH/S_SRCH_WAIT pass; in a linear ramp a 32-step progress
//   divide on the same shift-subtract unit and a scale by 1/255 follow.
//   One command is in work at a time; s_axis_tready is low meanwhile.
//   The result sits in an output register until taken, so a stalled receiver
//   holds the input off; the next command is accepted in the cycle the
//   result is taken. Reset clears playback, the start time and the registers
//   to their defaults; keyframe contents are not cleared.
// ----------------------------------------------------------------------------
module keyframe_duty_pattern_player_top #(
  parameter int MAX_KEYS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // key_index[3:0], key_offset_us[35:4], key_ramp_x4ms[43:36],
  // key_duty[50:44], key_linear[51], now_us[115:52], start_at_us[179:116]
  input  wire logic [183:0] s_axis_tdata,
  // func[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // drive_update[0], duty[7:1], is_playing[8], finished[9], status[10]
  output logic [15:0]       m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import kdpp_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SRCH, S_SRCH_WAIT, S_EVAL, S_PREV, S_PREV_WAIT,
    S_RDIV, S_QDIV, S_OUT
  } state_t;

  state_t state;

  // input fields
  logic [1:0]  in_func;
  logic [3:0]  in_index;
  logic [63:0] in_now, in_start;
  key_t        in_key;
  assign in_func         = s_axis_tuser;
  assign in_index        = s_axis_tdata[3:0];
  assign in_key.offset   = s_axis_tdata[35:4];
  assign in_key.ramp     = s_axis_tdata[43:36];
  assign in_key.duty     = (s_axis_tdata[50:44] > DUTY_MAX) ? DUTY_MAX
                                                             : s_axis_tdata[50:44];
  assign in_key.linear   = s_axis_tdata[51];
  assign in_now          = s_axis_tdata[115:52];
  assign in_start        = s_axis_tdata[179:116];

  // configuration registers
  logic [4:0]  key_count;
  logic [31:0] pattern_length_us;
  logic        loop_enable;
  logic [CW-1:0] keys_used;
  assign cfg_ready = 1'b1;
  assign keys_used = ({27'd0, key_count} < 32'(MAX_KEYS)) ? CW'(key_count)
                                                          : CW'(MAX_KEYS);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count         <= 5'd0;
      pattern_length_us <= 32'd1000000;
      loop_enable       <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LINE_COUNT: key_count         <= cfg_data[4:0];
        REG_LENGTH:     pattern_length_us <= cfg_data;
        REG_LOOP:       loop_enable       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // keyframe ram
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [KEY_W-1:0] ram_rdata;
  key_t          rkey;
  assign ram_we = s_axis_tvalid && s_axis_tready && (in_func == FUNC_WRITE)
                  && ({28'd0, in_index} < 32'(MAX_KEYS));
  assign rkey = key_t'(ram_rdata);

  kdpp_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_index)),
    .wdata (KEY_W'(in_key)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared shift-subtract divider registers
  logic [63:0] dv_num;   // dividend shifting out / quotient shifting in
  logic [32:0] dv_rem;
  logic [31:0] dv_den;
  logic [6:0]  dv_cnt;
  logic [32:0] dv_try;
  assign dv_try = {dv_rem[31:0], dv_num[63]} - {1'b0, dv_den};

  // working registers
  logic [63:0] play_origin;
  logic        playing;
  logic [31:0] pos;
  logic [CW-1:0] srch;
  key_t        cur;
  logic [AW-1:0] cur_idx;
  logic [6:0]  from_duty;
  logic [7:0]  progress;
  logic        diff_neg;
  logic [6:0]  diff_mag;
  logic [14:0] prod;
  logic [15:0] q_sum;
  logic [63:0] elapsed;
  logic [31:0] t_in, ramp_us;
  logic        r_drive, r_fin, r_status;
  logic [6:0]  r_duty;
  assign elapsed = in_now - play_origin;
  assign t_in    = pos - cur.offset;
  assign ramp_us = 32'(cur.ramp) * 32'(RAMP_UNIT_US);
  // floor(prod / 255) for prod below 65535
  assign q_sum   = {1'b0, prod} + 16'd1 + {9'd0, prod[14:8]};

  assign s_axis_tready = (state == S_IDLE) || (state == S_OUT && m_axis_tready);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {5'd0, r_status, r_fin, playing, r_duty, r_drive};
  assign ram_raddr     = (state == S_PREV) ? cur_idx - AW'(1) : AW'(srch - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      playing     <= 1'b0;
      play_origin <= 64'd0;
      r_drive     <= 1'b0;
      r_fin       <= 1'b0;
      r_status    <= 1'b0;
      r_duty      <= 7'd0;
    end else begin
      case (state)
        S_IDLE, S_OUT: begin
          if (s_axis_tvalid && s_axis_tready) begin
            r_drive  <= 1'b0;
            r_duty   <= 7'd0;
            r_fin    <= 1'b0;
            r_status <= 1'b0;
            state    <= S_OUT;
            case (in_func)
              FUNC_START: begin
                if (keys_used == '0) begin
                  r_status <= 1'b1;
                end else begin
                  play_origin <= (in_start != 64'd0) ? in_start : in_now;
                  playing     <= 1'b1;
                end
              end
              FUNC_STOP: begin
                if (playing) begin
                  playing <= 1'b0;
                  r_drive <= 1'b1;
                end
              end
              FUNC_TICK: begin
                if (playing && !elapsed[63] && pattern_length_us != 32'd0) begin
                  r_drive <= 1'b1;
                  if (loop_enable) begin
                    dv_num <= elapsed;
                    dv_rem <= 33'd0;
                    dv_den <= pattern_length_us;
                    dv_cnt <= 7'd64;
                    state  <= S_DIV;
                  end else if (elapsed >= {32'd0, pattern_length_us}) begin
                    playing <= 1'b0;
                    r_fin   <= 1'b1;
                  end else begin
                    pos   <= elapsed[31:0];
                    srch  <= keys_used;
                    state <= (keys_used == '0) ? S_OUT : S_SRCH;
                  end
                end
              end
              default: ;
            endcase
          end else if (state == S_OUT && m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        // one remainder bit per cycle
        S_DIV: begin
          if (!dv_try[32]) begin
            dv_rem <= dv_try;
          end else begin
            dv_rem <= {dv_rem[31:0], dv_num[63]};
          end
          dv_num <= {dv_num[62:0], ~dv_try[32]};
          dv_cnt <= dv_cnt - 7'd1;
          if (dv_cnt == 7'd1) begin
            pos   <= !dv_try[32] ? dv_try[31:0] : {dv_rem[30:0], dv_num[63]};
            srch  <= keys_used;
            state <= (keys_used == '0) ? S_OUT : S_SRCH;
          end
        end
        // ram read issued at srch-1
        S_SRCH: state <= S_SRCH_WAIT;
        S_SRCH_WAIT: begin
          if (rkey.offset <= pos || srch == CW'(1)) begin
            cur     <= rkey;
            cur_idx <= AW'(srch - CW'(1));
            state   <= S_EVAL;
          end else begin
            srch  <= srch - CW'(1);
            state <= S_SRCH;
          end
        end
        S_EVAL: begin
          if (!cur.linear || cur.ramp == 8'd0 || t_in >= ramp_us) begin
            r_duty <= cur.duty;
            state  <= S_OUT;
          end else if (cur_idx == '0) begin
            from_duty <= 7'd0;
            state     <= S_PREV_WAIT;
          end else begin
            state <= S_PREV;
          end
        end
        S_PREV: state <= S_PREV_WAIT;
        // start progress divide: t_in*255 / ramp_us
        S_PREV_WAIT: begin
          if (cur_idx != '0) begin
            from_duty <= rkey.duty;
          end
          dv_num <= {(t_in << 8) - t_in, 32'd0};
          dv_rem <= 33'd0;
          dv_den <= ramp_us;
          dv_cnt <= 7'd32;
          state  <= S_RDIV;
        end
        S_RDIV: begin
          if (!dv_try[32]) begin
            dv_rem <= dv_try;
          end else begin
            dv_rem <= {dv_rem[31:0], dv_num[63]};
          end
          dv_num <= {dv_num[62:0], ~dv_try[32]};
          if (dv_cnt == 7'd1) begin
            progress <= {dv_num[6:0], ~dv_try[32]};
            diff_neg <= cur.duty < from_duty;
            diff_mag <= (cur.duty < from_duty) ? from_duty - cur.duty
                                               : cur.duty - from_duty;
            state    <= S_QDIV;
            dv_cnt   <= 7'd0;
          end else begin
            dv_cnt <= dv_cnt - 7'd1;
          end
        end
        // |diff|*progress / 255 by shift-add, truncated toward zero
        S_QDIV: begin
          if (dv_cnt == 7'd0) begin
            prod   <= diff_mag * progress;
            dv_cnt <= 7'd1;
          end else begin
            r_duty <= diff_neg ? from_duty - q_sum[14:8]
                               : from_duty + q_sum[14:8];
            state  <= S_OUT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a finished one-shot has always stopped playback
  a_fin_stops: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[9] |-> !m_axis_tdata[8] && m_axis_tdata[0])
    else $error("finished beat while still playing");
  // no input while a command is in work
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_OUT) |-> !s_axis_tready)
    else $error("ready during work");
  // driven duty stays in range
  a_duty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:1] <= DUTY_MAX)
    else $error("duty out of range");
`endif

endmodule
`default_nettype wire

>>> dv/kdpp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdpp_checker
// watches the command, result and register channels of the pattern player,
// predicts the result of every accepted command beat and compares each
// result beat field by field with the oldest prediction
// ----------------------------------------------------------------------------
module kdpp_checker
  import kdpp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [183:0] s_axis_tdata,
  input  wire logic [1:0]   s_axis_tuser,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [15:0]  m_axis_tdata,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  output int                errors,
  output int                outstanding
);

  typedef struct packed {
    logic       status;
    logic       finished;
    logic       is_playing;
    logic [6:0] duty;
    logic       drive_update;
  } result_t;

  // predicted player state
  key_t        keys [16];
  logic [63:0] play_start;
  logic        playing;
  logic [4:0]  key_count;
  logic [31:0] length_us;
  logic        loop_en;
  result_t     expected_results [$];

  assign outstanding = expected_results.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // duty at a position within the pattern
  function automatic logic [6:0] duty_at_pos(input logic [31:0] pos);
    int          n;
    int          idx;
    key_t        k;
    logic [31:0] ramp_us;
    logic [31:0] t_in;
    logic [31:0] progress;
    int          prev;
    int          diff;
    int          q;
    n = (key_count > 16) ? 16 : int'(key_count);
    if (n == 0) return 7'd0;
    idx = 0;
    for (int i = n; i > 0; i--) begin
      if (keys[i-1].offset <= pos) begin
        idx = i - 1;
        break;
      end
    end
    k = keys[idx];
    if (!k.linear || k.ramp == 8'd0) return k.duty;
    ramp_us = 32'(k.ramp) * 32'd4000;
    t_in = pos - k.offset;
    if (t_in >= ramp_us) return k.duty;
    prev = (idx > 0) ? int'(keys[idx-1].duty) : 0;
    progress = (t_in * 32'd255) / ramp_us;
    diff = int'(k.duty) - prev;
    q = (diff * int'(progress)) / 255;
    return 7'(prev + q);
  endfunction

  // result of one command beat, updating the predicted state
  function automatic result_t play_command(input logic [1:0] func, input logic [183:0] d);
    result_t     r;
    logic [63:0] now;
    logic [63:0] start_at;
    logic [63:0] elapsed;
    logic [6:0]  kd;
    r = '0;
    now = d[115:52];
    start_at = d[179:116];
    case (func)
      FUNC_WRITE: begin
        kd = d[50:44];
        keys[d[3:0]].offset = d[35:4];
        keys[d[3:0]].ramp = d[43:36];
        keys[d[3:0]].duty = (kd > DUTY_MAX) ? DUTY_MAX : kd;
        keys[d[3:0]].linear = d[51];
      end
      FUNC_START: begin
        if (key_count == 5'd0) begin
          r.status = 1'b1;
        end else begin
          play_start = (start_at != 64'd0) ? start_at : now;
          playing = 1'b1;
        end
      end
      FUNC_STOP: begin
        if (playing) begin
          playing = 1'b0;
          r.drive_update = 1'b1;
        end
      end
      default: begin
        elapsed = now - play_start;
        if (playing && !elapsed[63] && length_us != 32'd0) begin
          r.drive_update = 1'b1;
          if (loop_en) begin
            r.duty = duty_at_pos(32'(elapsed % {32'd0, length_us}));
          end else if (elapsed >= {32'd0, length_us}) begin
            playing = 1'b0;
            r.finished = 1'b1;
          end else begin
            r.duty = duty_at_pos(elapsed[31:0]);
          end
        end
      end
    endcase
    r.is_playing = playing;
    return r;
  endfunction

  // follow the channels
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      play_start <= 64'd0;
      playing <= 1'b0;
      key_count <= 5'd0;
      length_us <= 32'd1000000;
      loop_en <= 1'b1;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LINE_COUNT: key_count = cfg_data[4:0];
          REG_LENGTH:     length_us = cfg_data;
          REG_LOOP:       loop_en = cfg_data[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(play_command(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[10:0];
        if (expected_results.size() == 0) begin
          report("unexpected result beat", 32'(got), 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.drive_update != want.drive_update)
            report("drive_update", 32'(got.drive_update), 32'(want.drive_update));
          if (got.duty != want.duty) report("duty", 32'(got.duty), 32'(want.duty));
          if (got.is_playing != want.is_playing)
            report("is_playing", 32'(got.is_playing), 32'(want.is_playing));
          if (got.finished != want.finished)
            report("finished", 32'(got.finished), 32'(want.finished));
          if (got.status != want.status)
            report("status", 32'(got.status), 32'(want.status));
          if (m_axis_tdata[15:11] != 5'd0)
            report("pad bits", 32'(m_axis_tdata[15:11]), 32'd0);
        end
      end
    end
  end

  initial errors = 0;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives the pattern player with directed then random command beats over
// several register settings and idling modes, and reports the verdict
// ----------------------------------------------------------------------------
module tb_top;
  import kdpp_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [183:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [15:0]  m_axis_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;
  int           errors;
  int           outstanding;

  int           send_idle_pct;
  int           recv_stall_pct;
  logic         long_hold;
  event         hold_request;
  logic [63:0]  now_t;
  logic [31:0]  cur_length;

  keyframe_duty_pattern_player_top u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  kdpp_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: random stalls, plus a long hold-off on request
  initial long_hold = 1'b0;
  always begin
    @(hold_request);
    @(negedge clk);
    long_hold = 1'b1;
    repeat (600) @(negedge clk);
    long_hold = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // command beat from fields: func in the low two bits, tdata above
  function automatic logic [185:0] pack_cmd(input logic [1:0] func, input logic [3:0] idx,
                                            input logic [31:0] off, input logic [7:0] ramp,
                                            input logic [6:0] duty, input logic lin,
                                            input logic [63:0] now, input logic [63:0] start_at);
    return {4'b0000, start_at, now, lin, duty, ramp, off, idx, func};
  endfunction

  // offer one command beat and wait for its acceptance
  task automatic send_cmd(input logic [185:0] d);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= d[1:0];
    s_axis_tdata <= d[185:2];
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop valid and let every result come home
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [4:0] lines, input logic [31:0] len, input logic lp);
    drain();
    write_reg(REG_LINE_COUNT, {27'd0, lines});
    write_reg(REG_LENGTH, len);
    write_reg(REG_LOOP, {31'd0, lp});
    cur_length = len;
  endtask

  task automatic tick_at(input logic [63:0] t);
    send_cmd(pack_cmd(FUNC_TICK, 4'($urandom), $urandom, 8'($urandom), 7'($urandom),
                      1'($urandom), t, 64'($urandom)));
  endtask

  // one random command, mostly well-formed playback traffic
  task automatic random_cmd;
    int          r;
    logic [31:0] off;
    logic [63:0] st;
    r = $urandom_range(99);
    if (r < 3) begin
      send_cmd(pack_cmd(2'($urandom), 4'($urandom), $urandom, 8'($urandom), 7'($urandom),
                        1'($urandom), {$urandom, $urandom}, {$urandom, $urandom}));
    end else if (r < 13) begin
      off = ($urandom_range(3) == 0 || cur_length == 32'd0) ? $urandom
            : $urandom % cur_length;
      send_cmd(pack_cmd(FUNC_WRITE, 4'($urandom), off, 8'($urandom),
                        7'($urandom_range(0, 127)), 1'($urandom), now_t, 64'($urandom)));
    end else if (r < 20) begin
      case ($urandom_range(4))
        0: st = now_t + $urandom_range(1, 50000);
        1: st = now_t - $urandom_range(1, 50000);
        2: st = {$urandom, $urandom};
        default: st = 64'd0;
      endcase
      send_cmd(pack_cmd(FUNC_START, 4'($urandom), $urandom, 8'($urandom), 7'($urandom),
                        1'($urandom), now_t, st));
    end else if (r < 24) begin
      send_cmd(pack_cmd(FUNC_STOP, 4'($urandom), $urandom, 8'($urandom), 7'($urandom),
                        1'($urandom), now_t, 64'($urandom)));
    end else begin
      if ($urandom_range(49) == 0) now_t = {$urandom, $urandom};
      else now_t = now_t + $urandom_range(0, 3000);
      tick_at(now_t);
    end
  endtask

  // stimulus
  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = FUNC_WRITE;
    cfg_valid = 1'b0;
    cfg_index = REG_LINE_COUNT;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    now_t = 64'd5000;
    cur_length = 32'd1000000;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: fill every slot, including extremes and duty saturation
    send_cmd(pack_cmd(FUNC_WRITE, 4'd0, 32'd1000, 8'd10, 7'd60, 1'b1, 64'd0, 64'd0));
    send_cmd(pack_cmd(FUNC_WRITE, 4'd1, 32'd5000, 8'd255, 7'd127, 1'b1, 64'd0, 64'd0));
    send_cmd(pack_cmd(FUNC_WRITE, 4'd2, 32'hFFFF_FFFF, 8'd0, 7'd0, 1'b0, 64'd0, 64'd0));
    for (int i = 3; i < 16; i++)
      send_cmd(pack_cmd(FUNC_WRITE, 4'(i), 32'(i * 60000), 8'($urandom),
                        7'($urandom_range(0, 110)), 1'($urandom), 64'd0, 64'd0));
    // start with no keyframes, stop and tick while idle
    send_cmd(pack_cmd(FUNC_START, 4'd0, 32'd0, 8'd0, 7'd0, 1'b0, 64'd100, 64'd0));
    send_cmd(pack_cmd(FUNC_STOP, 4'd0, 32'd0, 8'd0, 7'd0, 1'b0, 64'd100, 64'd0));
    tick_at(64'd200);
    set_regs(5'd3, 32'd20000, 1'b1);
    // start now, before first offset, inside ramps, wrap
    send_cmd(pack_cmd(FUNC_START, 4'd0, 32'd0, 8'd0, 7'd0, 1'b0, 64'd5000, 64'd0));
    tick_at(64'd5500);
    tick_at(64'd6500);
    tick_at(64'd12000);
    tick_at(64'd26000);
    // start in the future: tick before it, start at the top of time
    send_cmd(pack_cmd(FUNC_START, 4'd0, 32'd0, 8'd0, 7'd0, 1'b0, 64'd100, 64'd90000));
    tick_at(64'd80000);
    send_cmd(pack_cmd(FUNC_START, 4'd0, 32'd0, 8'd0, 7'd0, 1'b0, 64'd0, '1));
    tick_at('1);
    send_cmd(pack_cmd(FUNC_STOP, 4'd0, 32'd0, 8'd0, 7'd0, 1'b0, 64'd0, 64'd0));

    // random phases over register settings and idling modes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(5'd4, 32'd20000, 1'b1);
        1: set_regs(5'd16, 32'd1000000, 1'b1);
        2: set_regs(5'd0, 32'd30000, 1'b1);
        3: set_regs(5'd1, 32'd50000, 1'b0);
        4: set_regs(5'd16, 32'hFFFF_FFFF, 1'b0);
        5: set_regs(5'd8, 32'd0, 1'b1);
        6: set_regs(5'd16, 32'd7000, 1'b0);
        default: set_regs(5'($urandom_range(1, 16)), $urandom_range(1000, 200000),
                          1'($urandom));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (ph == 1) -> hold_request;
      for (int n = 0; n < 205; n++) begin
        if (n == 100) drain();
        random_cmd();
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("keyframe_duty_pattern_player_top: match");
    end else begin
      $display("keyframe_duty_pattern_player_top: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #(64'd200_000_000);
    $display("keyframe_duty_pattern_player_top: mismatch");
    $finish;
  end

endmodule
